// ===== rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file of the time-of-day clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, held off while reset is high.
`define BTOD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define BTOD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTOD_ASSERT(name, clk, rst, prop, msg)
`define BTOD_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== rtl/btod_pkg.sv =====
// Types, codes and BCD digit helpers for the time-of-day clock.
`timescale 1ns / 1ps

package btod_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [3:0] REG_CTRL      = 4'd0;
  localparam logic [3:0] REG_TENTHS    = 4'd1;
  localparam logic [3:0] REG_SEC_UNITS = 4'd2;
  localparam logic [3:0] REG_SEC_TENS  = 4'd3;
  localparam logic [3:0] REG_MIN_UNITS = 4'd4;
  localparam logic [3:0] REG_MIN_TENS  = 4'd5;
  localparam logic [3:0] REG_HR_UNITS  = 4'd6;
  localparam logic [3:0] REG_HR_TENS   = 4'd7;
  localparam logic [3:0] REG_DAY_UNITS = 4'd8;
  localparam logic [3:0] REG_DAY_TENS  = 4'd9;
  localparam logic [3:0] REG_MON_UNITS = 4'd10;
  localparam logic [3:0] REG_MON_TENS  = 4'd11;
  localparam logic [3:0] REG_YR_UNITS  = 4'd12;
  localparam logic [3:0] REG_YR_TENS   = 4'd13;
  localparam logic [3:0] REG_WEEKDAY   = 4'd14;
  localparam logic [3:0] REG_SETTING   = 4'd15;

  // Bit positions in the clock setting and control nibbles
  localparam int SET_24H_BIT   = 0;
  localparam int SET_PM_BIT    = 1;
  localparam int CTRL_STOP_BIT = 2;

  localparam logic [7:0] HUND_MAX  = 8'd99;
  localparam logic [7:0] SEC_MAX   = 8'd59;
  localparam logic [7:0] MIN_MAX   = 8'd59;
  localparam logic [7:0] HR12_MAX  = 8'd12;
  localparam logic [7:0] HR24_MAX  = 8'd23;
  localparam logic [7:0] MON_MAX   = 8'd12;
  localparam logic [7:0] YEAR_MAX  = 8'd99;

  typedef struct packed {
    logic [7:0] hundredths;
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [7:0] day_of_month;
    logic [7:0] month;
    logic [7:0] year;
    logic [2:0] weekday;
    logic [3:0] clock_setting;  // bits 3:2 hold the leap-year counter
    logic       data_changed;
    logic       running;
  } state_t;

  // All counters and flags clear, 12-hour mode, clock running
  localparam state_t STATE_RESET = '{
    hundredths:    8'd0,
    seconds:       8'd0,
    minutes:       8'd0,
    hours:         8'd0,
    day_of_month:  8'd0,
    month:         8'd0,
    year:          8'd0,
    weekday:       3'd0,
    clock_setting: 4'd0,
    data_changed:  1'b0,
    running:       1'b1
  };

  // v / 10 by reciprocal, exact for every 8-bit value
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return p[15:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [7:0] r;
    r = v - ({3'd0, div10(v)} * 8'd10);
    return r[3:0];
  endfunction

  function automatic logic [3:0] digit_read(input logic [7:0] v, input logic tens);
    logic [4:0] q;
    q = div10(v);
    return tens ? q[3:0] : mod10(v);
  endfunction

  // Replace one decimal digit of a binary counter, wrapping modulo 256
  function automatic logic [7:0] digit_write(input logic [7:0] cur, input logic [3:0] d,
                                             input logic tens);
    logic [7:0] r;
    if (tens) begin
      r = ({4'd0, d} * 8'd10) + {4'd0, mod10(cur)};
    end else begin
      r = ({3'd0, div10(cur)} * 8'd10) + {4'd0, d};
    end
    return r;
  endfunction

  // Last day of the month; 256 for months outside 1..12 so no wrap happens
  function automatic logic [8:0] month_limit(input logic [7:0] m, input logic [1:0] leap);
    logic [8:0] lim;
    case (m)
      8'd2:                            lim = (leap == 2'd0) ? 9'd29 : 9'd28;
      8'd4, 8'd6, 8'd9, 8'd11:         lim = 9'd30;
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8,
      8'd10, 8'd12:                    lim = 9'd31;
      default:                         lim = 9'd256;
    endcase
    return lim;
  endfunction

endpackage

// ===== rtl/btod_tick.sv =====
// Rollover cascade for one 10 ms tick: time of day, then date.
`timescale 1ns / 1ps

module btod_tick import btod_pkg::*; (
  input  state_t cur,
  output state_t nxt
);

  logic       adv;
  logic [7:0] hun;
  logic [7:0] sec;
  logic [7:0] mins;
  logic [7:0] hr;
  logic [2:0] wd;
  logic [7:0] dom;
  logic [7:0] dom_fix;
  logic [7:0] mon;
  logic [7:0] yr;
  logic [1:0] leap;

  always_comb begin
    nxt  = cur;
    adv  = 1'b0;
    hun  = cur.hundredths + 8'd1;
    sec  = cur.seconds + 8'd1;
    mins = cur.minutes + 8'd1;
    hr   = cur.hours + 8'd1;

    if (hun <= HUND_MAX) begin
      nxt.hundredths = hun;
    end else begin
      nxt.hundredths   = 8'd0;
      nxt.data_changed = 1'b1;
      if (sec <= SEC_MAX) begin
        nxt.seconds = sec;
      end else begin
        nxt.seconds = 8'd0;
        if (mins <= MIN_MAX) begin
          nxt.minutes = mins;
        end else begin
          nxt.minutes = 8'd0;
          if (!cur.clock_setting[SET_24H_BIT]) begin
            nxt.hours = (hr > HR12_MAX) ? 8'd1 : hr;
            if (hr == HR12_MAX) begin
              // toggle PM; the date moves only when PM goes clear (midnight)
              nxt.clock_setting[SET_PM_BIT] = ~cur.clock_setting[SET_PM_BIT];
              adv = cur.clock_setting[SET_PM_BIT];
            end
          end else begin
            nxt.hours = (hr > HR24_MAX) ? 8'd0 : hr;
            adv = (hr > HR24_MAX) || (hr == 8'd0);
          end
        end
      end
    end

    wd      = cur.weekday + 3'd1;
    dom     = cur.day_of_month + 8'd1;
    dom_fix = ({1'b0, dom} > month_limit(cur.month, cur.clock_setting[3:2])) ? 8'd1 : dom;
    mon     = cur.month + 8'd1;
    yr      = cur.year + 8'd1;
    leap    = cur.clock_setting[3:2] + 2'd1;

    if (adv) begin
      nxt.weekday      = (wd == 3'd0) ? 3'd1 : wd;
      nxt.day_of_month = dom_fix;
      if (dom_fix == 8'd1) begin
        if (mon > MON_MAX) begin
          nxt.month              = 8'd1;
          nxt.clock_setting[3:2] = leap;
          nxt.year               = (yr > YEAR_MAX) ? 8'd0 : yr;
        end else begin
          nxt.month = mon;
        end
      end
    end
  end

endmodule

// ===== rtl/btod_access.sv =====
// Register read and write decode over the BCD digit view of the counters.
`timescale 1ns / 1ps

module btod_access import btod_pkg::*; (
  input  state_t     cur,
  input  logic [1:0] mode,
  input  logic [3:0] reg_index,
  input  logic [3:0] write_data,
  output state_t     nxt,
  output logic [3:0] read_data
);

  logic tens;

  assign tens = reg_index[0];

  always_comb begin
    nxt       = cur;
    read_data = 4'd0;
    if (mode == MODE_READ) begin
      case (reg_index)
        REG_CTRL: begin
          read_data[CTRL_STOP_BIT] = cur.data_changed;
          nxt.data_changed         = 1'b0;
        end
        REG_TENTHS:                   read_data = digit_read(cur.hundredths, 1'b1);
        REG_SEC_UNITS, REG_SEC_TENS:  read_data = digit_read(cur.seconds, tens);
        REG_MIN_UNITS, REG_MIN_TENS:  read_data = digit_read(cur.minutes, tens);
        REG_HR_UNITS, REG_HR_TENS:    read_data = digit_read(cur.hours, tens);
        REG_DAY_UNITS, REG_DAY_TENS:  read_data = digit_read(cur.day_of_month, tens);
        REG_MON_UNITS, REG_MON_TENS:  read_data = digit_read(cur.month, tens);
        REG_YR_UNITS, REG_YR_TENS:    read_data = digit_read(cur.year, tens);
        REG_WEEKDAY:                  read_data = {1'b0, cur.weekday};
        default:                      read_data = cur.clock_setting;
      endcase
    end else if (mode == MODE_WRITE) begin
      case (reg_index)
        REG_CTRL: begin
          if (write_data[CTRL_STOP_BIT]) begin
            nxt.running    = 1'b0;
            nxt.hundredths = 8'd0;
          end else begin
            nxt.running = 1'b1;
          end
        end
        REG_TENTHS:                   nxt.hundredths = {4'd0, write_data} * 8'd10;
        REG_SEC_UNITS, REG_SEC_TENS:
          nxt.seconds = digit_write(cur.seconds, write_data, tens);
        REG_MIN_UNITS, REG_MIN_TENS:
          nxt.minutes = digit_write(cur.minutes, write_data, tens);
        REG_HR_UNITS, REG_HR_TENS:
          nxt.hours = digit_write(cur.hours, write_data, tens);
        REG_DAY_UNITS, REG_DAY_TENS:
          nxt.day_of_month = digit_write(cur.day_of_month, write_data, tens);
        REG_MON_UNITS, REG_MON_TENS:
          nxt.month = digit_write(cur.month, write_data, tens);
        REG_YR_UNITS, REG_YR_TENS:
          nxt.year = digit_write(cur.year, write_data, tens);
        REG_WEEKDAY:                  nxt.weekday = write_data[2:0];
        default: begin
          // 24-hour mode drops PM; bits 3:2 load the leap-year counter
          nxt.clock_setting = write_data;
          if (write_data[SET_24H_BIT]) begin
            nxt.clock_setting[SET_PM_BIT] = 1'b0;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/bcd_time_of_day_clock.sv =====
// Path: a word accepted into the input register moves on to the result register when
// that register is free, and the result word leaves while out_stall is low.
// Throughput: one word per cycle; the input register and result register keep both
// sides moving, and the input side stalls only while a held result blocks the queue.
// Each word updates the clock state in the same cycle its result is registered.
// Reset (rst, synchronous, active high) zeroes all counters and flags, selects
// 12-hour mode and leaves the clock running.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcd_time_of_day_clock import btod_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [3:0] reg_index,
  input  logic [3:0] write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] read_data
);

  // Input register: holds one accepted word until the result register can take it
  logic       s1_valid;
  logic [1:0] s1_mode;
  logic [3:0] s1_index;
  logic [3:0] s1_data;

  logic out_free;
  logic s1_fire;
  logic in_take;

  state_t     st;
  state_t     st_next;
  state_t     st_tick;
  state_t     st_acc;
  logic [3:0] acc_rd;
  logic [3:0] rd_next;

  // The result register may load when empty or when its word leaves this cycle
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Payload needs no reset; load it only on an accepted word
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode  <= mode;
      s1_index <= reg_index;
      s1_data  <= write_data;
    end
  end

  btod_tick u_tick (
    .cur (st),
    .nxt (st_tick)
  );

  btod_access u_access (
    .cur        (st),
    .mode       (s1_mode),
    .reg_index  (s1_index),
    .write_data (s1_data),
    .nxt        (st_acc),
    .read_data  (acc_rd)
  );

  // Choose the state update: advance on a tick while running, else decode the access.
  // The unused mode code leaves the state alone and answers zero.
  always_comb begin
    st_next = st;
    rd_next = 4'd0;
    case (s1_mode)
      MODE_TICK: begin
        if (st.running) begin
          st_next = st_tick;
        end
      end
      MODE_READ, MODE_WRITE: begin
        st_next = st_acc;
        rd_next = acc_rd;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      read_data <= rd_next;
    end
  end

  // 24-hour mode never carries a PM flag
  `BTOD_ASSERT(a_pm_clear_24h, clk, rst, st.clock_setting[SET_24H_BIT] |-> !st.clock_setting[SET_PM_BIT], "PM set in 24-hour mode")
  // Only a waiting word can hold the input side off
  `BTOD_ASSERT(a_stall_needs_word, clk, rst, in_stall |-> s1_valid, "input stalled with empty input register")
  // Ticks, writes and the unused mode answer zero
  `BTOD_ASSERT(a_zero_unless_read, clk, rst, (s1_fire && (s1_mode != MODE_READ)) |=> (read_data == 4'd0), "non-read result not zero")
  // A word that moves on always lands in the result register
  `BTOD_ASSERT(a_fire_fills_out, clk, rst, s1_fire |=> out_valid, "word lost between stages")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the BCD time-of-day clock: directed, sequence and random words.
`timescale 1ns / 1ps

module tb_top;
  import btod_pkg::*;

  // Mode 3 has no name in the package; the block must answer it with zero
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Control read reports the data-changed flag in this bit
  localparam int CHANGED_FLAG_BIT = 2;
  localparam int LONG_HOLD = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] mode = MODE_TICK;
  logic [3:0] reg_index = REG_CTRL;
  logic [3:0] write_data = 4'h0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] read_data;

  bcd_time_of_day_clock dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .reg_index  (reg_index),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Clock state as the testbench expects it to be
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] hund;
    logic [7:0] sec;
    logic [7:0] mins;
    logic [7:0] hrs;
    logic [7:0] mday;
    logic [7:0] mon;
    logic [7:0] yr;
    logic [2:0] wday;
    logic [1:0] leap;      // 0 means a leap year
    logic [3:0] setting;   // 24h select, PM, leap counter mirror
    logic       changed;
    logic       run;
  } tod_state_t;

  // One result word still owed by the block, with the word that caused it
  typedef struct {
    logic [3:0] digit;
    logic [1:0] mode;
    logic [3:0] idx;
  } readback_t;

  tod_state_t tod;
  readback_t  readback_q[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;

  logic src_gaps_on = 1'b1;
  logic sink_stalls_on = 1'b1;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   stall_left = 0;

  function automatic logic [3:0] units_of(logic [7:0] v);
    return 4'(v % 8'd10);
  endfunction

  // Tens digit keeps only its low nibble, so 150 reads back as 15
  function automatic logic [3:0] tens_of(logic [7:0] v);
    return 4'(v / 8'd10);
  endfunction

  function automatic logic [7:0] put_units(logic [7:0] cur, logic [3:0] d);
    int s;
    s = int'(cur / 8'd10) * 10 + int'(d);
    return s[7:0];
  endfunction

  function automatic logic [7:0] put_tens(logic [7:0] cur, logic [3:0] d);
    int s;
    s = int'(d) * 10 + int'(cur % 8'd10);
    return s[7:0];
  endfunction

  // Day count of a month; months outside 1..12 never wrap the day
  function automatic int unsigned month_length(logic [7:0] m, logic [1:0] lp);
    case (m)
      8'd2:                                     return (lp == 2'd0) ? 29 : 28;
      8'd4, 8'd6, 8'd9, 8'd11:                  return 30;
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: return 31;
      default:                                  return 256;
    endcase
  endfunction

  function void model_reset();
    tod.hund = 8'd0;
    tod.sec = 8'd0;
    tod.mins = 8'd0;
    tod.hrs = 8'd0;
    tod.mday = 8'd0;
    tod.mon = 8'd0;
    tod.yr = 8'd0;
    tod.wday = 3'd0;
    tod.leap = 2'd0;
    tod.setting = 4'd0;
    tod.changed = 1'b0;
    tod.run = 1'b1;
  endfunction

  // Advance weekday and date by one day, carrying into month and year
  function void roll_date();
    tod.wday = tod.wday + 3'd1;
    if (tod.wday == 3'd0) tod.wday = 3'd1;
    tod.mday = tod.mday + 8'd1;
    if (32'(tod.mday) > month_length(tod.mon, tod.leap)) tod.mday = 8'd1;
    if (tod.mday == 8'd1) begin
      tod.mon = tod.mon + 8'd1;
      if (tod.mon > MON_MAX) begin
        tod.mon = 8'd1;
        tod.leap = tod.leap + 2'd1;
        tod.setting = {tod.leap, tod.setting[1:0]};
        tod.yr = tod.yr + 8'd1;
        if (tod.yr > YEAR_MAX) tod.yr = 8'd0;
      end
    end
  endfunction

  // One 10 ms tick: each counter only carries when it passes its limit
  function void clock_tick();
    tod.hund = tod.hund + 8'd1;
    if (tod.hund <= HUND_MAX) return;
    tod.hund = 8'd0;
    tod.changed = 1'b1;
    tod.sec = tod.sec + 8'd1;
    if (tod.sec <= SEC_MAX) return;
    tod.sec = 8'd0;
    tod.mins = tod.mins + 8'd1;
    if (tod.mins <= MIN_MAX) return;
    tod.mins = 8'd0;
    tod.hrs = tod.hrs + 8'd1;
    if (!tod.setting[SET_24H_BIT]) begin
      // Reaching 12 flips PM; the date moves only when PM drops, at midnight
      if (tod.hrs == HR12_MAX) begin
        tod.setting[SET_PM_BIT] = ~tod.setting[SET_PM_BIT];
        if (!tod.setting[SET_PM_BIT]) roll_date();
      end
      if (tod.hrs > HR12_MAX) tod.hrs = 8'd1;
    end else begin
      if (tod.hrs > HR24_MAX) tod.hrs = 8'd0;
      if (tod.hrs == 8'd0) roll_date();
    end
  endfunction

  function logic [3:0] model_read(logic [3:0] idx);
    logic [3:0] r;
    r = 4'd0;
    case (idx)
      REG_CTRL: begin
        r[CHANGED_FLAG_BIT] = tod.changed;
        tod.changed = 1'b0;
      end
      REG_TENTHS:    r = tens_of(tod.hund);
      REG_SEC_UNITS: r = units_of(tod.sec);
      REG_SEC_TENS:  r = tens_of(tod.sec);
      REG_MIN_UNITS: r = units_of(tod.mins);
      REG_MIN_TENS:  r = tens_of(tod.mins);
      REG_HR_UNITS:  r = units_of(tod.hrs);
      REG_HR_TENS:   r = tens_of(tod.hrs);
      REG_DAY_UNITS: r = units_of(tod.mday);
      REG_DAY_TENS:  r = tens_of(tod.mday);
      REG_MON_UNITS: r = units_of(tod.mon);
      REG_MON_TENS:  r = tens_of(tod.mon);
      REG_YR_UNITS:  r = units_of(tod.yr);
      REG_YR_TENS:   r = tens_of(tod.yr);
      REG_WEEKDAY:   r = {1'b0, tod.wday};
      default:       r = tod.setting;
    endcase
    return r;
  endfunction

  function void model_write(logic [3:0] idx, logic [3:0] d);
    case (idx)
      REG_CTRL: begin
        if (d[CTRL_STOP_BIT]) begin
          tod.run = 1'b0;
          tod.hund = 8'd0;
        end else begin
          tod.run = 1'b1;
        end
      end
      REG_TENTHS:    tod.hund = 8'(int'(d) * 10);
      REG_SEC_UNITS: tod.sec = put_units(tod.sec, d);
      REG_SEC_TENS:  tod.sec = put_tens(tod.sec, d);
      REG_MIN_UNITS: tod.mins = put_units(tod.mins, d);
      REG_MIN_TENS:  tod.mins = put_tens(tod.mins, d);
      REG_HR_UNITS:  tod.hrs = put_units(tod.hrs, d);
      REG_HR_TENS:   tod.hrs = put_tens(tod.hrs, d);
      REG_DAY_UNITS: tod.mday = put_units(tod.mday, d);
      REG_DAY_TENS:  tod.mday = put_tens(tod.mday, d);
      REG_MON_UNITS: tod.mon = put_units(tod.mon, d);
      REG_MON_TENS:  tod.mon = put_tens(tod.mon, d);
      REG_YR_UNITS:  tod.yr = put_units(tod.yr, d);
      REG_YR_TENS:   tod.yr = put_tens(tod.yr, d);
      REG_WEEKDAY:   tod.wday = d[2:0];
      default: begin
        tod.setting = d;
        if (d[SET_24H_BIT]) tod.setting[SET_PM_BIT] = 1'b0;
        tod.leap = d[3:2];
      end
    endcase
  endfunction

  // Apply one word to the expected state and return the digit it answers with
  function logic [3:0] clock_predict(logic [1:0] m, logic [3:0] idx, logic [3:0] d);
    logic [3:0] r;
    r = 4'd0;
    case (m)
      MODE_TICK:  if (tod.run) clock_tick();
      MODE_READ:  r = model_read(idx);
      MODE_WRITE: model_write(idx, d);
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  function void log_mismatch(string what, logic [3:0] want, logic [3:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected %h, got %h", what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one word, sometimes after a random gap, and hold it until accepted.
  // in_stall is read just after the edge, so it is the value the block saw.
  task automatic offer_word(input logic [1:0] m, input logic [3:0] idx,
                            input logic [3:0] d);
    readback_t rb;
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    reg_index <= idx;
    write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rb.mode = m;
    rb.idx = idx;
    rb.digit = clock_predict(m, idx, d);
    readback_q.push_back(rb);
  endtask

  // Write a counter through its two digits; the tens register sits just above units
  task automatic load_counter(input logic [3:0] units_reg, input logic [7:0] v);
    offer_word(MODE_WRITE, units_reg, 4'(v % 8'd10));
    offer_word(MODE_WRITE, units_reg + 4'd1, 4'(v / 8'd10));
  endtask

  task automatic offer_ticks(input int n);
    repeat (n) offer_word(MODE_TICK, 4'($urandom), 4'($urandom));
  endtask

  // Anything goes: ticks, reads, writes of any digit and the unused mode
  task automatic offer_random_word();
    int pick;
    logic [1:0] m;
    pick = $urandom_range(0, 9);
    if (pick < 4) m = MODE_TICK;
    else if (pick < 7) m = MODE_READ;
    else if (pick < 9) m = MODE_WRITE;
    else m = MODE_UNUSED;
    offer_word(m, 4'($urandom), 4'($urandom));
  endtask

  // Drop valid and hold until every owed word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
  endtask

  // Set the clock just short of a rollover, tick across it, then read it back
  task automatic run_rollover_sequence();
    logic [3:0] set_v;
    logic [3:0] ctrl_v;
    logic [7:0] mon_v;
    logic [7:0] day_v;
    logic [7:0] hr_v;
    int unsigned lim;
    set_v = 4'($urandom);
    offer_word(MODE_WRITE, REG_SETTING, set_v);
    offer_word(MODE_WRITE, REG_WEEKDAY, 4'($urandom));
    load_counter(REG_YR_UNITS, ($urandom_range(0, 2) == 0) ? YEAR_MAX
                                                           : 8'($urandom_range(0, 99)));
    case ($urandom_range(0, 5))
      0, 1:    mon_v = MON_MAX;
      2, 3, 4: mon_v = 8'($urandom_range(1, 12));
      default: mon_v = 8'($urandom_range(0, 25));   // often an invalid month
    endcase
    load_counter(REG_MON_UNITS, mon_v);
    lim = month_length(mon_v, set_v[3:2]);
    if (lim == 256) day_v = 8'($urandom_range(0, 99));
    else if ($urandom_range(0, 1) == 0) day_v = 8'(lim);
    else day_v = 8'($urandom_range(1, lim));
    load_counter(REG_DAY_UNITS, day_v);
    if (set_v[SET_24H_BIT]) begin
      hr_v = ($urandom_range(0, 2) != 0) ? HR24_MAX : 8'($urandom_range(0, 23));
    end else begin
      case ($urandom_range(0, 3))
        0:       hr_v = 8'd11;
        1:       hr_v = HR12_MAX;
        2:       hr_v = 8'($urandom_range(0, 12));
        default: hr_v = 8'($urandom_range(13, 19));  // past 12, folds to 1
      endcase
    end
    load_counter(REG_HR_UNITS, hr_v);
    load_counter(REG_MIN_UNITS, ($urandom_range(0, 3) != 0) ? MIN_MAX
                                                           : 8'($urandom_range(0, 59)));
    load_counter(REG_SEC_UNITS, ($urandom_range(0, 3) != 0) ? SEC_MAX
                                                           : 8'($urandom_range(0, 59)));
    offer_word(MODE_WRITE, REG_TENTHS, 4'($urandom_range(9, 15)));
    // Mostly run; now and then stop, which also clears the hundredths
    ctrl_v = 4'($urandom);
    ctrl_v[CTRL_STOP_BIT] = ($urandom_range(0, 7) == 0);
    offer_word(MODE_WRITE, REG_CTRL, ctrl_v);
    offer_ticks($urandom_range(1, 12));
    if ($urandom_range(0, 1) == 0) offer_word(MODE_READ, REG_CTRL, 4'($urandom));
    repeat ($urandom_range(2, 6)) offer_word(MODE_READ, 4'($urandom), 4'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    offer_word(MODE_READ, REG_CTRL, 4'h0);          // nothing has changed yet
    offer_word(MODE_UNUSED, REG_SETTING, 4'hF);     // unused mode answers zero
    // Noon in 12-hour mode: PM sets, the date stays
    load_counter(REG_SEC_UNITS, SEC_MAX);
    load_counter(REG_MIN_UNITS, MIN_MAX);
    load_counter(REG_HR_UNITS, 8'd11);
    offer_word(MODE_WRITE, REG_TENTHS, 4'hF);       // 150, out of range: next tick carries
    offer_word(MODE_TICK, REG_CTRL, 4'h0);
    offer_word(MODE_READ, REG_SETTING, 4'h0);
    offer_word(MODE_READ, REG_CTRL, 4'h0);          // flag reported ...
    offer_word(MODE_READ, REG_CTRL, 4'hF);          // ... and cleared
    // Midnight: weekday 7 wraps to 1, month 0 is invalid yet still advances
    offer_word(MODE_WRITE, REG_WEEKDAY, 4'hF);
    load_counter(REG_SEC_UNITS, SEC_MAX);
    load_counter(REG_MIN_UNITS, MIN_MAX);
    offer_word(MODE_WRITE, REG_HR_UNITS, 4'h1);     // 12 -> 11, PM still set
    offer_word(MODE_WRITE, REG_TENTHS, 4'hF);
    offer_word(MODE_TICK, REG_SETTING, 4'hF);
    offer_word(MODE_READ, REG_WEEKDAY, 4'h0);
    offer_word(MODE_READ, REG_DAY_UNITS, 4'h0);
    offer_word(MODE_READ, REG_MON_UNITS, 4'h0);
    // Stopped clock ignores ticks
    offer_word(MODE_WRITE, REG_CTRL, 4'h4);
    offer_word(MODE_TICK, REG_TENTHS, 4'h0);
    offer_word(MODE_READ, REG_TENTHS, 4'h0);
    offer_word(MODE_WRITE, REG_CTRL, 4'hB);
  endtask

  task automatic test_rollover_sequences(input int n);
    repeat (n) run_rollover_sequence();
  endtask

  task automatic test_random_noise(input int n);
    repeat (n) offer_random_word();
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // block fills and stalls its input
  task automatic test_input_backpressure();
    src_gaps_on = 1'b0;
    hold_req <= ~hold_req;
    repeat (60) offer_random_word();
    src_gaps_on = 1'b1;
  endtask

  // Pause the sender mid-run until the block has emptied, then carry on
  task automatic test_drain_pause();
    run_rollover_sequence();
    wait_drained();
    run_rollover_sequence();
  endtask

  // Last stretch with no idling on either side
  task automatic test_steady_stream();
    src_gaps_on = 1'b0;
    sink_stalls_on <= 1'b0;
    repeat (8) run_rollover_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: check each accepted word, then decide the next stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_side
    readback_t head;
    if (!rst && out_valid && !out_stall) begin
      if (readback_q.size() == 0) begin
        log_mismatch("result word with nothing pending", 4'hx, read_data);
      end else begin
        head = readback_q.pop_front();
        if (read_data !== head.digit)
          log_mismatch($sformatf("read_data for mode %0d reg %0d", head.mode, head.idx),
                       head.digit, read_data);
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && sink_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_rollover_sequences(45);
    test_random_noise(300);
    test_input_backpressure();
    test_drain_pause();
    test_steady_stream();
    // Let the last words through, then give stray results a chance to show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/btod_pkg.sv
rtl/btod_tick.sv
rtl/btod_access.sv
rtl/bcd_time_of_day_clock.sv
tb/sv/tb_top.sv
